>>> design/tslf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslf_pkg
// shared constants, types and character codes of the line formatter
// ----------------------------------------------------------------------------
package tslf_pkg;

  localparam int unsigned NUMBER_DIGITS = 6;
  localparam int unsigned REND_MAX      = 4;
  localparam int unsigned MAX_BYTES     = NUMBER_DIGITS + 1 + REND_MAX;
  localparam int unsigned LEN_W         = $clog2(MAX_BYTES + 1);
  localparam int unsigned IDX_W         = $clog2(MAX_BYTES);
  localparam int unsigned BCD_W         = 4 * NUMBER_DIGITS;
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned QPTR_W        = $clog2(QDEPTH);
  localparam int unsigned QCNT_W        = $clog2(QDEPTH + 1);
  localparam int unsigned ADDR_W        = 5;

  // register indexes
  localparam logic [2:0] REG_NUMBER_MODE = 3'd0;
  localparam logic [2:0] REG_SQUEEZE     = 3'd1;
  localparam logic [2:0] REG_SHOW_NP     = 3'd2;
  localparam logic [2:0] REG_SHOW_ENDS   = 3'd3;
  localparam logic [2:0] REG_SHOW_TABS   = 3'd4;

  // numbering modes
  localparam logic [1:0] NUM_NONE         = 2'd0;
  localparam logic [1:0] NUM_ALL          = 2'd1;
  localparam logic [1:0] NUM_NONBLANK     = 2'd2;
  localparam logic [1:0] NUM_NONBLANK_ALT = 2'd3;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_I      = 8'd73;
  localparam logic [7:0] CH_M      = 8'd77;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_TILDE  = 8'd126;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_HI_PR  = 8'd160;
  localparam logic [7:0] CH_FF     = 8'd255;
  localparam logic [7:0] OFS_CTRL  = 8'd64;
  localparam logic [7:0] OFS_META  = 8'd128;

  typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;
  localparam bcd_t BCD_ONE = {{(BCD_W-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_en;
    logic       show_nonprinting;
    logic       mark_ends;
    logic       mark_tabs;
  } cfg_t;

  // one job: the bytes caused by one input word, first byte at index 0
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
  } job_t;

endpackage

>>> design/tslf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslf_in_if / tslf_out_if
// valid/ready channels carrying raw and formatted bytes
// ----------------------------------------------------------------------------
interface tslf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tslf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

>>> design/tslf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslf_front
// classifies each input word, keeps line state and builds the output job
// ----------------------------------------------------------------------------
module tslf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tslf_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output tslf_pkg::job_t    job_o
);
  import tslf_pkg::*;

  logic at_ls_q, at_ls_d;
  logic prev_blank_q, prev_blank_d;
  bcd_t count_q, count_d;

  logic       accept;
  logic       blank;
  logic       squeeze;
  logic       numbered;
  logic [REND_MAX-1:0][7:0] rend;
  logic [LEN_W-1:0]         rlen;
  logic [NUMBER_DIGITS-1:0][7:0] digit_ch;
  bcd_t       count_inc;
  logic       all_nines;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign blank      = (in_byte_i == CH_LF);
  assign squeeze    = at_ls_q && cfg_i.squeeze_en && blank && prev_blank_q;
  assign numbered   = at_ls_q && (cfg_i.number_mode[1] ? !blank
                                                       : (cfg_i.number_mode == NUM_ALL));
  assign push_o     = accept && !squeeze;

  // number digits, most significant first, leading zeros as spaces
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int d = NUMBER_DIGITS - 1; d >= 0; d--) begin
      if (seen || count_q[d] != 4'd0 || d == 0) begin
        seen = 1'b1;
        digit_ch[NUMBER_DIGITS-1-d] = CH_ZERO + {4'd0, count_q[d]};
      end else begin
        digit_ch[NUMBER_DIGITS-1-d] = CH_SPACE;
      end
    end
  end

  // saturating decimal increment
  always_comb begin
    logic carry;
    carry     = 1'b1;
    all_nines = 1'b1;
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      if (count_q[d] != 4'd9) all_nines = 1'b0;
    end
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      if (carry && count_q[d] >= 4'd9) begin
        count_inc[d] = 4'd0;
      end else if (carry) begin
        count_inc[d] = count_q[d] + 4'd1;
        carry        = 1'b0;
      end else begin
        count_inc[d] = count_q[d];
      end
    end
  end

  // rendering of the byte itself
  always_comb begin
    rend = '0;
    rlen = LEN_W'(1);
    if (cfg_i.mark_tabs && in_byte_i == CH_TAB) begin
      rend[0] = CH_CARET;
      rend[1] = CH_I;
      rlen    = LEN_W'(2);
    end else if (blank) begin
      if (cfg_i.mark_ends) begin
        rend[0] = CH_DOLLAR;
        rend[1] = CH_LF;
        rlen    = LEN_W'(2);
      end else begin
        rend[0] = CH_LF;
      end
    end else if (cfg_i.show_nonprinting && in_byte_i != CH_TAB &&
                 (in_byte_i < CH_SPACE || in_byte_i > CH_TILDE)) begin
      if (in_byte_i < CH_SPACE) begin
        rend[0] = CH_CARET;
        rend[1] = in_byte_i + OFS_CTRL;
        rlen    = LEN_W'(2);
      end else if (in_byte_i == CH_DEL) begin
        rend[0] = CH_CARET;
        rend[1] = CH_QMARK;
        rlen    = LEN_W'(2);
      end else begin
        rend[0] = CH_M;
        rend[1] = CH_DASH;
        if (in_byte_i < CH_HI_PR) begin
          rend[2] = CH_CARET;
          rend[3] = in_byte_i - OFS_CTRL;
          rlen    = LEN_W'(4);
        end else if (in_byte_i == CH_FF) begin
          rend[2] = CH_CARET;
          rend[3] = CH_QMARK;
          rlen    = LEN_W'(4);
        end else begin
          rend[2] = in_byte_i - OFS_META;
          rlen    = LEN_W'(3);
        end
      end
    end else begin
      rend[0] = in_byte_i;
    end
  end

  // job assembly: optional number and tab, then the rendered bytes
  always_comb begin
    job_o.bytes = '0;
    for (int p = 0; p < MAX_BYTES; p++) begin
      if (numbered) begin
        if (p < NUMBER_DIGITS) begin
          job_o.bytes[p] = digit_ch[p];
        end else if (p == NUMBER_DIGITS) begin
          job_o.bytes[p] = CH_TAB;
        end else begin
          job_o.bytes[p] = rend[p-NUMBER_DIGITS-1];
        end
      end else if (p < REND_MAX) begin
        job_o.bytes[p] = rend[p];
      end
    end
    job_o.len = numbered ? rlen + LEN_W'(NUMBER_DIGITS + 1) : rlen;
  end

  always_comb begin
    at_ls_d      = at_ls_q;
    prev_blank_d = prev_blank_q;
    count_d      = count_q;
    if (push_o) begin
      at_ls_d = blank;
      if (at_ls_q) prev_blank_d = blank;
      if (numbered && !all_nines) count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_ls_q      <= 1'b1;
      prev_blank_q <= 1'b0;
      count_q      <= BCD_ONE;
    end else begin
      at_ls_q      <= at_ls_d;
      prev_blank_q <= prev_blank_d;
      count_q      <= count_d;
    end
  end

endmodule

>>> design/tslf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslf_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module tslf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tslf_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tslf_pkg::job_t head_o
);
  import tslf_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + QCNT_W'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> design/tslf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslf_back
// serialises the head job into output words through an output register
// ----------------------------------------------------------------------------
module tslf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tslf_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  input  logic           out_ready_i
);
  import tslf_pkg::*;

  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             load;
  logic             is_last;

  assign load    = !valid_q || out_ready_i;
  assign is_last = (LEN_W'(idx_q) + LEN_W'(1)) == head_i.len;
  assign pop_o   = load && !empty_i && is_last;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        byte_d = head_i.bytes[idx_q];
        last_d = is_last;
        idx_d  = is_last ? '0 : idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = last_q;

endmodule

>>> design/text_stream_line_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_stream_line_formatter
// line numbering, blank squeezing and visible rendering of a byte stream
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+---------------------------
//  in_i     | in  | valid / ready   | in_byte
//  out_o    | out | valid / ready   | out_byte, run_last
//  apb      | in  | psel / penable  | paddr, pwdata, prdata
//
//  a raw word is taken whenever the job queue has room; the back end sends
//  one output word per cycle while the receiver is ready, so plain text
//  flows at one word a cycle and a word that expands to n bytes holds the
//  source while its bytes go out once the two-entry queue has filled
//  reset is asynchronous active low; there is no clearing pass
//  the output register lets the next word be accepted while a word waits
// ----------------------------------------------------------------------------
module text_stream_line_formatter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tslf_in_if.sink                     in_i,
  tslf_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tslf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tslf_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  logic push, pop, full, empty;
  job_t job_in, job_head;

  // register file, word aligned
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_NUMBER_MODE: cfg_d.number_mode      = pwdata[1:0];
        REG_SQUEEZE:     cfg_d.squeeze_en       = pwdata[0];
        REG_SHOW_NP:     cfg_d.show_nonprinting = pwdata[0];
        REG_SHOW_ENDS:   cfg_d.mark_ends        = pwdata[0];
        REG_SHOW_TABS:   cfg_d.mark_tabs        = pwdata[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_NUMBER_MODE: prdata = {30'd0, cfg_q.number_mode};
      REG_SQUEEZE:     prdata = {31'd0, cfg_q.squeeze_en};
      REG_SHOW_NP:     prdata = {31'd0, cfg_q.show_nonprinting};
      REG_SHOW_ENDS:   prdata = {31'd0, cfg_q.mark_ends};
      REG_SHOW_TABS:   prdata = {31'd0, cfg_q.mark_tabs};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: line state, numbering and rendering decisions
  tslf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .in_ready_o (in_i.ready),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  // decouples the front from a stalled or busy back end
  tslf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (job_head)
  );

  // back: one output word per cycle from the head job while the receiver is ready
  tslf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (job_head),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .run_last_o  (out_o.run_last),
    .out_ready_i (out_o.ready)
  );

endmodule

>>> test/text_stream_line_formatter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_stream_line_formatter_test
// self-checking bench for the line formatter: a byte-level formatter model
// tracks line starts, blank lines and the bcd line number, and every word on
// the output channel is checked against it under random stalls on both sides
// ----------------------------------------------------------------------------
module text_stream_line_formatter_test;
  import tslf_pkg::*;

  localparam int STALL_LIMIT  = 1000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 16;    // job queue plus output register, with margin
  localparam int LONG_HOLD    = 150;   // receiver hold-off in the pressure test
  localparam int PHASE_WORDS  = 46;    // raw words per random configuration phase
  localparam int PHASES       = 8;

  // one formatted byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } fmt_word_t;

  logic        clk_i;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tslf_in_if  raw_bus ();
  tslf_out_if fmt_bus ();

  text_stream_line_formatter u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_n),
    .in_i    (raw_bus),
    .out_o   (fmt_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // formatter state as the bench sees it
  cfg_t      fmt_cfg;
  logic      at_line_head;
  logic      last_line_blank;
  bcd_t      line_no;
  fmt_word_t due_text[$];

  int mismatches;
  int words_sent;
  int quiet_cycles;
  int hold_ask;
  bit tx_calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // line number moves on by one, sticking at all nines
  function automatic void bump_line_no();
    bit saturated;
    saturated = 1'b1;
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      if (line_no[d] != 4'd9) saturated = 1'b0;
    end
    if (saturated) return;
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      if (line_no[d] == 4'd9) begin
        line_no[d] = 4'd0;  // wraps, carry goes on
      end else begin
        line_no[d] = line_no[d] + 4'd1;
        break;
      end
    end
  endfunction

  // works out the formatted bytes caused by one raw byte
  function automatic void format_raw_byte(input logic [7:0] ch);
    logic       blank;
    logic       numbered;
    logic       lead;
    logic [7:0] run[$];
    fmt_word_t  w;
    if (at_line_head) begin
      blank = (ch == CH_LF);
      // a repeated blank line vanishes and the stream stays at a line start
      if (fmt_cfg.squeeze_en && blank && last_line_blank) return;
      last_line_blank = blank;
      // mode three counts as non-blank numbering
      if (fmt_cfg.number_mode[1]) begin
        numbered = !blank;
      end else begin
        numbered = (fmt_cfg.number_mode == NUM_ALL);
      end
      if (numbered) begin
        lead = 1'b1;
        for (int d = NUMBER_DIGITS - 1; d >= 0; d--) begin
          if (lead && line_no[d] == 4'd0 && d != 0) begin
            run.push_back(CH_SPACE);
          end else begin
            lead = 1'b0;
            run.push_back(CH_ZERO + {4'd0, line_no[d]});
          end
        end
        run.push_back(CH_TAB);
        bump_line_no();
      end
    end

    if (fmt_cfg.mark_tabs && ch == CH_TAB) begin
      run.push_back(CH_CARET);
      run.push_back(CH_I);
    end else if (ch == CH_LF) begin
      if (fmt_cfg.mark_ends) run.push_back(CH_DOLLAR);
      run.push_back(CH_LF);
    end else if (fmt_cfg.show_nonprinting && ch != CH_TAB &&
                 (ch < CH_SPACE || ch > CH_TILDE)) begin
      if (ch < CH_SPACE) begin
        run.push_back(CH_CARET);
        run.push_back(ch + OFS_CTRL);
      end else if (ch == CH_DEL) begin
        run.push_back(CH_CARET);
        run.push_back(CH_QMARK);
      end else begin
        // meta bytes: M- then the low half rendered again
        run.push_back(CH_M);
        run.push_back(CH_DASH);
        if (ch < CH_HI_PR) begin
          run.push_back(CH_CARET);
          run.push_back(ch - OFS_CTRL);
        end else if (ch == CH_FF) begin
          run.push_back(CH_CARET);
          run.push_back(CH_QMARK);
        end else begin
          run.push_back(ch - OFS_META);
        end
      end
    end else begin
      run.push_back(ch);
    end

    at_line_head = (ch == CH_LF);

    foreach (run[k]) begin
      w.data = run[k];
      w.last = (k == run.size() - 1);
      due_text.push_back(w);
    end
  endfunction

  // one raw word offered until taken, after an optional gap
  task automatic send_raw(input logic [7:0] ch);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 99) < 30) gap = idle_span();
    if (gap > 0) begin
      raw_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // valid stays high straight into the next word when there is no gap
    raw_bus.valid   <= 1'b1;
    raw_bus.in_byte <= ch;
    do @(posedge clk_i); while (!raw_bus.ready);
    format_raw_byte(ch);
    words_sent++;
    if ($urandom_range(0, 59) == 0) tx_calm = !tx_calm;
  endtask

  // drop valid, wait for every expected word, then let the queue run dry
  task automatic settle();
    raw_bus.valid <= 1'b0;
    while (due_text.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // apb write, mirror update and read-back of one register
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_NUMBER_MODE: fmt_cfg.number_mode      = value[1:0];
      REG_SQUEEZE:     fmt_cfg.squeeze_en       = value[0];
      REG_SHOW_NP:     fmt_cfg.show_nonprinting = value[0];
      REG_SHOW_ENDS:   fmt_cfg.mark_ends        = value[0];
      REG_SHOW_TABS:   fmt_cfg.mark_tabs        = value[0];
      default: ;
    endcase

    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== value) begin
      $display("%0t: register %0d read back expected %08h got %08h",
               $time, idx, value, rd);
      mismatches++;
    end
  endtask

  // whole register set, written only once the block has gone quiet
  task automatic set_format(input logic [1:0] mode, input logic squeeze,
                            input logic np, input logic ends, input logic tabs);
    settle();
    write_reg(REG_NUMBER_MODE, {30'd0, mode});
    write_reg(REG_SQUEEZE, {31'd0, squeeze});
    write_reg(REG_SHOW_NP, {31'd0, np});
    write_reg(REG_SHOW_ENDS, {31'd0, ends});
    write_reg(REG_SHOW_TABS, {31'd0, tabs});
  endtask

  // one line of random content ending in a newline, or a burst of noise
  task automatic send_random_line();
    int         len;
    int         pick;
    logic [7:0] ch;
    if ($urandom_range(0, 9) == 0) begin
      // noise: any byte at all, newlines included
      repeat ($urandom_range(1, 6)) send_raw(8'($urandom_range(0, 255)));
      return;
    end
    len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        ch = 8'($urandom_range(CH_SPACE, CH_TILDE));
      end else if (pick < 60) begin
        ch = CH_TAB;
      end else if (pick < 75) begin
        ch = 8'($urandom_range(0, CH_SPACE - 1));
        if (ch == CH_LF) ch = CH_TAB;
      end else begin
        ch = 8'($urandom_range(CH_DEL, CH_FF));
      end
      send_raw(ch);
    end
    send_raw(CH_LF);
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // no formatting at all: every byte goes through untouched
  task automatic test_plain_passthrough();
    set_format(NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_raw(8'h00);
    send_raw(8'hff);
    send_raw("A");
    send_raw(CH_TAB);
    send_raw(CH_LF);
  endtask

  // every line numbered, tab and line-end markers on, blank line numbered too
  task automatic test_number_all();
    set_format(NUM_ALL, 1'b0, 1'b0, 1'b1, 1'b1);
    send_raw(CH_TAB);
    send_raw(CH_LF);
    send_raw(CH_LF);
  endtask

  // non-blank numbering with squeeze, then numbering mode three
  task automatic test_nonblank_squeeze();
    set_format(NUM_NONBLANK, 1'b1, 1'b0, 1'b0, 1'b0);
    send_raw(CH_LF);
    send_raw(CH_LF);  // dropped
    send_raw(CH_LF);  // dropped
    send_raw("x");
    send_raw(CH_LF);
    set_format(NUM_NONBLANK_ALT, 1'b1, 1'b0, 1'b0, 1'b0);
    send_raw(CH_LF);
    send_raw("y");
  endtask

  // caret and meta notation across every range boundary
  task automatic test_nonprinting();
    set_format(NUM_NONE, 1'b0, 1'b1, 1'b0, 1'b0);
    send_raw(8'h00);
    send_raw(CH_SPACE - 8'd1);
    send_raw(CH_DEL);
    send_raw(OFS_META);
    send_raw(CH_HI_PR - 8'd1);
    send_raw(CH_HI_PR);
    send_raw(CH_FF);
    send_raw(CH_TAB);    // tab stays raw with tab display off
    send_raw(CH_TILDE);
    send_raw(CH_LF);
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_back_pressure();
    bit calm_before;
    set_format(NUM_ALL, 1'b0, 1'b1, 1'b1, 1'b1);
    calm_before = tx_calm;
    tx_calm     = 1'b1;
    hold_ask++;
    repeat (30) begin
      if ($urandom_range(0, 4) == 0) begin
        send_raw(CH_LF);
      end else begin
        send_raw(8'($urandom_range(0, 255)));
      end
    end
    tx_calm = calm_before;
  endtask

  // random text over a sweep of settings, extremes first
  task automatic test_random_text();
    int goal;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_format(NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
        1: set_format(NUM_NONBLANK_ALT, 1'b1, 1'b1, 1'b1, 1'b1);
        2: set_format(NUM_ALL, 1'b0, 1'b0, 1'b1, 1'b0);
        3: set_format(NUM_NONBLANK, 1'b1, 1'b1, 1'b0, 1'b1);
        default: set_format(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
      endcase
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) send_random_line();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random ready with calm stretches and the long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int rx_left;
    int hold_taken;
    bit rx_calm;
    rx_left       = 0;
    hold_taken    = 0;
    rx_calm       = 1'b0;
    fmt_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_ask != hold_taken) begin
        hold_taken = hold_ask;
        rx_left    = LONG_HOLD;
        fmt_bus.ready <= 1'b0;
      end else if (rx_left > 0) begin
        rx_left--;
        fmt_bus.ready <= 1'b0;
      end else begin
        fmt_bus.ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 99) < 15) rx_left = idle_span();
      end
      if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
    end
  end

  // ---------------------------------------------------------------------------
  // output check: each word against the oldest expected one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    fmt_word_t want;
    if (rst_n && fmt_bus.valid && fmt_bus.ready) begin
      if (due_text.size() == 0) begin
        $display("%0t: unexpected word %02h last %0b", $time,
                 fmt_bus.out_byte, fmt_bus.run_last);
        mismatches++;
      end else begin
        want = due_text.pop_front();
        if (fmt_bus.out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time,
                   want.data, fmt_bus.out_byte);
          mismatches++;
        end
        if (fmt_bus.run_last !== want.last) begin
          $display("%0t: run_last expected %0b got %0b", $time,
                   want.last, fmt_bus.run_last);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no word moving on either channel
  always @(posedge clk_i) begin
    if ((raw_bus.valid && raw_bus.ready) || (fmt_bus.valid && fmt_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("FAIL text_stream_line_formatter");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    raw_bus.valid   = 1'b0;
    raw_bus.in_byte = 8'd0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = 32'd0;
    mismatches      = 0;
    words_sent      = 0;
    quiet_cycles    = 0;
    hold_ask        = 0;
    tx_calm         = 1'b0;
    // formatter state after reset
    fmt_cfg         = '0;
    at_line_head    = 1'b1;
    last_line_blank = 1'b0;
    line_no         = BCD_ONE;

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    test_plain_passthrough();
    test_number_all();
    test_nonblank_squeeze();
    test_nonprinting();
    test_back_pressure();
    test_random_text();

    settle();
    if (mismatches == 0) begin
      $display("PASS text_stream_line_formatter");
    end else begin
      $display("FAIL text_stream_line_formatter");
    end
    $finish;
  end

endmodule

>>> files.f
design/tslf_pkg.sv
design/tslf_if.sv
design/tslf_front.sv
design/tslf_queue.sv
design/tslf_back.sv
design/text_stream_line_formatter.sv
test/text_stream_line_formatter_test.sv
